// ===== rtl/core/pfc_pkg.sv =====
// Shared types, constants and helper functions for the Playfair digraph cipher.
package pfc_pkg;

  localparam int SIDE  = 5;
  localparam int CELLS = 25;
  localparam int POS_DEPTH = 26;
  localparam int LETTER_W = 5;

  localparam logic [4:0] CODE_I    = 5'd8;
  localparam logic [4:0] CODE_J    = 5'd9;
  localparam logic [4:0] CODE_X    = 5'd23;
  localparam logic [4:0] LAST_CODE = 5'd25;

  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_MSG = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [4:0] letter;
    logic       last;
  } pfc_in_t;

  typedef struct packed {
    logic [4:0] out_letter;
    logic       out_last;
  } pfc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_RD_A,
    ST_RD_B,
    ST_CALC,
    ST_RD_X,
    ST_RD_Y,
    ST_GET_Y,
    ST_EMIT_X,
    ST_EMIT_Y
  } pfc_state_t;

  typedef struct packed {
    logic load_item;
    logic decode;
    logic fill_step;
    logic rd_pos_b;
    logic cap_pa;
    logic calc;
    logic rd_cell_y;
    logic cap_x;
    logic cap_y;
    logic emit_x;
    logic emit_y;
    logic next_pair;
  } pfc_cmd_t;

  typedef struct packed {
    logic mode;
    logic last;
    logic pair_start;
    logic second;
    logic fill_done;
    logic out_free;
    logic skip_y;
  } pfc_status_t;

  function automatic logic [2:0] pfc_row(input logic [4:0] p);
    logic [2:0] r;
    if (p < 5'd5) begin
      r = 3'd0;
    end else if (p < 5'd10) begin
      r = 3'd1;
    end else if (p < 5'd15) begin
      r = 3'd2;
    end else if (p < 5'd20) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [2:0] pfc_col(input logic [4:0] p);
    logic [4:0] base;
    base = 5'(pfc_row(p)) * 5'(SIDE);
    return 3'(p - base);
  endfunction

  // +1 or -1 modulo the side length
  function automatic logic [2:0] pfc_shift(input logic [2:0] v, input logic dec);
    logic [2:0] r;
    if (dec) begin
      r = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
    end else begin
      r = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [4:0] pfc_cell(input logic [2:0] r, input logic [2:0] c);
    return 5'(r) * 5'(SIDE) + 5'(c);
  endfunction

endpackage

// ===== rtl/core/pfc_ram.sv =====
// Generic single write, single read RAM with registered read data.
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pfc_ctrl.sv =====
// Sequencer: request intake, square completion walk, digraph lookup and result issue.
module pfc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfc_pkg::pfc_status_t status,
  output pfc_pkg::pfc_cmd_t    cmd
);
  import pfc_pkg::*;

  pfc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.mode == MODE_KEY) begin
          state_next = status.last ? ST_FILL : ST_IDLE;
        end else begin
          state_next = status.pair_start ? ST_RD_A : ST_IDLE;
        end
      end
      ST_FILL: begin
        if (status.fill_done) state_next = ST_IDLE;
      end
      ST_RD_A:  state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_CALC;
      ST_CALC:  state_next = ST_RD_X;
      ST_RD_X:  state_next = ST_RD_Y;
      ST_RD_Y:  state_next = ST_GET_Y;
      ST_GET_Y: state_next = ST_EMIT_X;
      ST_EMIT_X: begin
        // a dropped trailing X only happens on the final pair
        if (status.out_free) state_next = status.skip_y ? ST_IDLE : ST_EMIT_Y;
      end
      ST_EMIT_Y: begin
        if (status.out_free) state_next = status.second ? ST_RD_A : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECODE: cmd.decode    = 1'b1;
      ST_FILL:   cmd.fill_step = 1'b1;
      ST_RD_A:   ;
      ST_RD_B: begin
        cmd.rd_pos_b = 1'b1;
        cmd.cap_pa   = 1'b1;
      end
      ST_CALC:   cmd.calc = 1'b1;
      ST_RD_X:   ;
      ST_RD_Y: begin
        cmd.rd_cell_y = 1'b1;
        cmd.cap_x     = 1'b1;
      end
      ST_GET_Y:  cmd.cap_y = 1'b1;
      ST_EMIT_X: cmd.emit_x = status.out_free;
      ST_EMIT_Y: begin
        cmd.emit_y    = status.out_free;
        cmd.next_pair = status.out_free && status.second;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/pfc_dpath.sv =====
// Datapath: square storage, letter positions, held letter, digraph arithmetic, output register.
module pfc_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  pfc_pkg::pfc_in_t     in_data,
  input  pfc_pkg::pfc_cmd_t    cmd,
  output pfc_pkg::pfc_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pfc_pkg::pfc_out_t    out_data
);
  import pfc_pkg::*;

  logic        decrypt_select;
  logic [POS_DEPTH-1:0] present, present_eff, present_next;
  logic [4:0]  fill_count, fill_eff, fill_next;
  logic        square_complete;
  logic        pending_valid;
  logic [4:0]  pending_letter;
  logic [4:0]  fill_ctr;

  logic        item_mode, item_valid, item_last;
  logic [4:0]  item_code;

  logic [4:0]  pair_a, pair_b;
  logic        pair_final, pair_second;
  logic [4:0]  pa, na, nb, x, y;

  logic        clear, place_req, place_ok;
  logic [4:0]  place_code;
  logic [4:0]  cell_rdata, pos_rdata;

  logic        is_msg, dbl, start;
  logic [4:0]  dec_a, dec_b;
  logic        dec_final, dec_second;

  logic [2:0]  ra, ca, rb, cb;
  logic [4:0]  na_next, nb_next;

  // ---- square build ----
  always_comb begin
    clear       = cmd.decode && item_mode == MODE_KEY && square_complete;
    present_eff = clear ? '0 : present;
    fill_eff    = clear ? 5'd0 : fill_count;
    place_code  = cmd.fill_step ? fill_ctr : item_code;
    place_req   = (cmd.decode && item_mode == MODE_KEY && item_valid) || cmd.fill_step;
    place_ok    = place_req && place_code != CODE_J && place_code <= LAST_CODE &&
                  !present_eff[place_code] && fill_eff < 5'(CELLS);
    present_next = present_eff;
    if (place_ok) present_next[place_code] = 1'b1;
    fill_next = place_ok ? fill_eff + 5'd1 : fill_eff;
  end

  // ---- message decode ----
  always_comb begin
    is_msg = item_mode == MODE_MSG && square_complete;
    dbl    = item_valid && pending_valid && !decrypt_select && pending_letter == item_code;
    if (!item_valid) begin
      start = item_last && pending_valid;
    end else begin
      start = pending_valid || item_last;
    end
    dec_a      = pending_valid ? pending_letter : item_code;
    dec_b      = (!item_valid || !pending_valid || dbl) ? CODE_X : item_code;
    dec_final  = !item_valid || !pending_valid || (!dbl && item_last);
    dec_second = dbl && item_last;
  end

  // ---- position to cell arithmetic ----
  always_comb begin
    ra = pfc_row(pa);
    ca = pfc_col(pa);
    rb = pfc_row(pos_rdata);
    cb = pfc_col(pos_rdata);
    if (ra == rb) begin
      na_next = pfc_cell(ra, pfc_shift(ca, decrypt_select));
      nb_next = pfc_cell(rb, pfc_shift(cb, decrypt_select));
    end else if (ca == cb) begin
      na_next = pfc_cell(pfc_shift(ra, decrypt_select), ca);
      nb_next = pfc_cell(pfc_shift(rb, decrypt_select), cb);
    end else begin
      na_next = pfc_cell(ra, cb);
      nb_next = pfc_cell(rb, ca);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_select  <= 1'b0;
      present         <= '0;
      fill_count      <= 5'd0;
      square_complete <= 1'b0;
      pending_valid   <= 1'b0;
      fill_ctr        <= 5'd0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) decrypt_select <= cfg_wdata;
      present    <= present_next;
      fill_count <= fill_next;
      if (clear) begin
        square_complete <= 1'b0;
        pending_valid   <= 1'b0;
      end else if (cmd.fill_step && fill_ctr == LAST_CODE) begin
        square_complete <= 1'b1;
      end
      if (cmd.decode) begin
        fill_ctr <= 5'd0;
      end else if (cmd.fill_step) begin
        fill_ctr <= fill_ctr + 5'd1;
      end
      if (cmd.decode && is_msg) begin
        if (!item_valid) begin
          if (item_last) pending_valid <= 1'b0;
        end else if (!pending_valid) begin
          pending_valid <= !item_last;
        end else if (dbl) begin
          pending_valid <= !item_last;
        end else begin
          pending_valid <= 1'b0;
        end
      end
      if (cmd.emit_x || cmd.emit_y) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode  <= in_data.mode;
      item_last  <= in_data.last;
      item_valid <= in_data.letter <= LAST_CODE;
      item_code  <= (in_data.letter == CODE_J) ? CODE_I : in_data.letter;
    end
    if (cmd.decode && is_msg && item_valid && !pending_valid && !item_last) begin
      pending_letter <= item_code;
    end
    if (cmd.decode) begin
      pair_a      <= dec_a;
      pair_b      <= dec_b;
      pair_final  <= dec_final;
      pair_second <= dec_second;
    end else if (cmd.next_pair) begin
      // held repeat that was also the last letter: pad it with X
      pair_a      <= item_code;
      pair_b      <= CODE_X;
      pair_final  <= 1'b1;
      pair_second <= 1'b0;
    end
    if (cmd.cap_pa) pa <= pos_rdata;
    if (cmd.calc) begin
      na <= na_next;
      nb <= nb_next;
    end
    if (cmd.cap_x) x <= cell_rdata;
    if (cmd.cap_y) y <= cell_rdata;
    if (cmd.emit_x) begin
      out_data.out_letter <= x;
      out_data.out_last   <= status.skip_y;
    end else if (cmd.emit_y) begin
      out_data.out_letter <= y;
      out_data.out_last   <= pair_final;
    end
  end

  pfc_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (place_ok),
    .waddr (fill_eff),
    .wdata (place_code),
    .raddr (cmd.rd_cell_y ? nb : na),
    .rdata (cell_rdata)
  );

  pfc_ram #(.WIDTH(LETTER_W), .DEPTH(POS_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (place_ok),
    .waddr (place_code),
    .wdata (fill_eff),
    .raddr (cmd.rd_pos_b ? pair_b : pair_a),
    .rdata (pos_rdata)
  );

  always_comb begin
    status.mode       = item_mode;
    status.last       = item_last;
    status.pair_start = is_msg && start;
    status.second     = pair_second;
    status.fill_done  = fill_ctr == LAST_CODE;
    status.out_free   = !out_valid || out_ready;
    status.skip_y     = decrypt_select && pair_final && y == CODE_X;
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_x || cmd.emit_y) |-> (!out_valid || out_ready))
    else $error("result issued while output register is occupied");

  a_complete_full: assert property (@(posedge clk) disable iff (rst)
    square_complete |-> fill_count == 5'(CELLS))
    else $error("square marked complete with empty cells");

  a_pending_needs_square: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> square_complete)
    else $error("held message letter without a complete square");

endmodule

// ===== rtl/core/playfair_digraph_cipher_unit.sv =====
// A keyword letter is decoded in turn; the last one adds an alphabet walk before idle.
// A digraph-closing message letter shows its first result after the request is taken
// (two position RAM reads, cell computation, two square RAM reads), the second when the output
// register is free; a split repeat that is also the final letter then adds a padded pair.
// One letter in flight: a new request is taken only once the previous one is through, stalls included.
// Reset (rst, synchronous): encrypt mode, empty square, no held letter; RAMs are not cleared.
module playfair_digraph_cipher_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfc_pkg::pfc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pfc_pkg::pfc_out_t out_data
);
  import pfc_pkg::*;

  pfc_cmd_t    cmd;
  pfc_status_t status;

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
